>>> sv/dlr_pkg.sv
// Shared types, codes and constants of the DDA line rasterizer.
package dlr_pkg;

  localparam int DEF_COORD_BITS = 13;
  localparam int DEF_FRAC_BITS  = 16;

  localparam int WIN_BITS     = 13;
  localparam int ADDR_BITS    = 24;
  localparam int COLOR_BITS   = 32;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [WIN_BITS-1:0] WIDTH_RST  = 13'd800;
  localparam logic [WIN_BITS-1:0] HEIGHT_RST = 13'd600;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 1'd1;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN,
    ST_RND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_start;
    logic load_step;
    logic load_none;
    logic div_run;
    logic div_fin;
    logic rnd;
    logic out_load;
  } dlr_cmd_t;

  typedef struct packed {
    logic act_step;
    logic line_active;
    logic div_done;
  } dlr_status_t;

endpackage

>>> sv/dda_line_rasterizer_top.sv
// Top level of the DDA line rasterizer: controller plus datapath.
//
//   channel | direction | handshake            | payload
//   in_     | into      | in_valid / in_stall  | action, endpoints, line color
//   out_    | out of    | out_valid / out_stall| produced, visible, x, y, address, color, last
//   cfg_    | into      | cfg_we               | cfg_index, cfg_data (window width/height)
//
// A start beat is loaded, then the restoring dividers form the x and y
// increments one quotient bit per cycle, then the increments are rounded,
// the pixel is rounded and the result register is loaded; only after that
// is the next input beat taken. A step beat is loaded, its pixel rounded and
// the result register loaded; a step beat with no active line goes from the
// load straight to the result register. The controller sequence sets this,
// not the result register: the next input beat is taken while a result waits,
// and the block holds in its result stage only while out_stall keeps the
// register full.
// Reset is synchronous, active low; window registers return to 800 x 600.
module dda_line_rasterizer_top import dlr_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_action,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic [COLOR_BITS-1:0]        in_line_color,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_produced,
  output logic                         out_visible,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic [ADDR_BITS-1:0]         out_address,
  output logic [COLOR_BITS-1:0]        out_pixel_color,
  output logic                         out_last,

  input  logic                         cfg_we,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [WIN_BITS-1:0]          cfg_data
);

  // Commands from the controller, status back from the datapath.
  dlr_cmd_t    cmd;
  dlr_status_t status;

  dlr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath holds the window registers, the line state, both dividers,
  // the pixel rounding and the result register.
  dlr_datapath #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_action       (in_action),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_line_color   (in_line_color),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_produced    (out_produced),
    .out_visible     (out_visible),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_address     (out_address),
    .out_pixel_color (out_pixel_color),
    .out_last        (out_last)
  );

endmodule

>>> sv/dlr_div.sv
// Restoring divider for one axis increment, one quotient bit per cycle.
module dlr_div import dlr_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  init,
  input  logic                  run,
  input  logic [COORD_BITS-1:0] mag,
  input  logic [COORD_BITS-1:0] divisor,
  output logic [FRAC_BITS:0]    q_round
);

  logic [COORD_BITS:0]   rem_r, rem_nxt;
  logic [FRAC_BITS:0]    q_r, q_nxt;
  logic                  ge;
  logic [COORD_BITS:0]   rem_sub;
  logic [COORD_BITS-1:0] rem_left;

  // ge doubles as the round-up test once all bits are done:
  // the final remainder is held doubled.
  assign ge       = rem_r >= {1'b0, divisor};
  assign rem_sub  = rem_r - {1'b0, divisor};
  assign rem_left = ge ? rem_sub[COORD_BITS-1:0] : rem_r[COORD_BITS-1:0];
  assign q_round  = q_r + (FRAC_BITS+1)'(ge);

  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    if (init) begin
      rem_nxt = {1'b0, mag};
      q_nxt   = '0;
    end else if (run) begin
      rem_nxt = {rem_left, 1'b0};
      q_nxt   = {q_r[FRAC_BITS-1:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

endmodule

>>> sv/dlr_datapath.sv
// Datapath: window registers, line state, dividers, rounding and result register.
module dlr_datapath import dlr_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dlr_cmd_t                     cmd,
  output dlr_status_t                  status,
  input  logic                         in_action,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic [COLOR_BITS-1:0]        in_line_color,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [WIN_BITS-1:0]          cfg_data,
  output logic                         out_produced,
  output logic                         out_visible,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic [ADDR_BITS-1:0]         out_address,
  output logic [COLOR_BITS-1:0]        out_pixel_color,
  output logic                         out_last
);

  localparam int POS_W  = COORD_BITS + 1 + FRAC_BITS;
  localparam int STEP_W = FRAC_BITS + 2;
  localparam int CNT_W  = $clog2(FRAC_BITS + 1);
  localparam int MUL_W  = WIN_BITS + COORD_BITS + 1;
  localparam int PROD_W = (MUL_W > ADDR_BITS) ? MUL_W : ADDR_BITS;
  localparam int CMP_W  = (COORD_BITS > WIN_BITS) ? COORD_BITS : WIN_BITS;
  localparam logic [POS_W-1:0] HALF    = POS_W'(1) << (FRAC_BITS - 1);
  localparam logic [POS_W-1:0] HALF_LO = HALF - POS_W'(1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(FRAC_BITS);

  logic [WIN_BITS-1:0] win_width_r, win_width_nxt;
  logic [WIN_BITS-1:0] win_height_r, win_height_nxt;

  logic signed [POS_W-1:0]  pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic signed [STEP_W-1:0] step_x_r, step_x_nxt, step_y_r, step_y_nxt;
  logic [COORD_BITS-1:0]    longest_r, longest_nxt;
  logic                     neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic [COORD_BITS-1:0]    steps_left_r, steps_left_nxt;
  logic                     line_active_r, line_active_nxt;
  logic                     last_r, last_nxt;
  logic                     produce_r, produce_nxt;
  logic [COLOR_BITS-1:0]    color_r, color_nxt;
  logic [CNT_W-1:0]         div_cnt_r, div_cnt_nxt;
  logic signed [COORD_BITS:0] px_r, px_nxt, py_r, py_nxt;

  logic                         out_produced_r, out_produced_nxt;
  logic                         out_visible_r, out_visible_nxt;
  logic signed [COORD_BITS-1:0] out_pixel_x_r, out_pixel_x_nxt;
  logic signed [COORD_BITS-1:0] out_pixel_y_r, out_pixel_y_nxt;
  logic [ADDR_BITS-1:0]         out_address_r, out_address_nxt;
  logic [COLOR_BITS-1:0]        out_pixel_color_r, out_pixel_color_nxt;
  logic                         out_last_r, out_last_nxt;

  logic signed [COORD_BITS:0] dx, dy, ndx, ndy;
  logic [COORD_BITS-1:0]      mag_x, mag_y, longest_in;
  logic [FRAC_BITS:0]         q_round_x, q_round_y;
  logic signed [STEP_W-1:0]   qx_s, qy_s;
  logic [POS_W-1:0]           rx_sum, ry_sum;
  logic                       vis;
  logic [PROD_W-1:0]          prod;

  // Endpoint deltas and the longest side, straight from the input beat.
  assign dx         = (COORD_BITS+1)'(in_end_x) - (COORD_BITS+1)'(in_start_x);
  assign dy         = (COORD_BITS+1)'(in_end_y) - (COORD_BITS+1)'(in_start_y);
  assign ndx        = -dx;
  assign ndy        = -dy;
  assign mag_x      = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
  assign mag_y      = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
  assign longest_in = (mag_x >= mag_y) ? mag_x : mag_y;

  dlr_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk     (clk),
    .init    (cmd.load_start),
    .run     (cmd.div_run),
    .mag     (mag_x),
    .divisor (longest_r),
    .q_round (q_round_x)
  );

  dlr_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk     (clk),
    .init    (cmd.load_start),
    .run     (cmd.div_run),
    .mag     (mag_y),
    .divisor (longest_r),
    .q_round (q_round_y)
  );

  assign qx_s = $signed({1'b0, q_round_x});
  assign qy_s = $signed({1'b0, q_round_y});

  // Round half away from zero in one add: bias by half, or half minus one
  // for negative positions, then floor.
  assign rx_sum = pos_x_r + (pos_x_r[POS_W-1] ? HALF_LO : HALF);
  assign ry_sum = pos_y_r + (pos_y_r[POS_W-1] ? HALF_LO : HALF);

  assign vis = !px_r[COORD_BITS] && !py_r[COORD_BITS] &&
               (CMP_W'(px_r[COORD_BITS-1:0]) < CMP_W'(win_width_r)) &&
               (CMP_W'(py_r[COORD_BITS-1:0]) < CMP_W'(win_height_r));
  assign prod = PROD_W'(win_width_r) * PROD_W'(py_r[COORD_BITS-1:0]);

  assign status.act_step    = (in_action == ACT_STEP);
  assign status.line_active = line_active_r;
  assign status.div_done    = (div_cnt_r == CNT_END);

  always_comb begin
    win_width_nxt  = win_width_r;
    win_height_nxt = win_height_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  win_width_nxt  = cfg_data;
        CFG_HEIGHT: win_height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_x_nxt       = pos_x_r;
    pos_y_nxt       = pos_y_r;
    step_x_nxt      = step_x_r;
    step_y_nxt      = step_y_r;
    longest_nxt     = longest_r;
    neg_x_nxt       = neg_x_r;
    neg_y_nxt       = neg_y_r;
    steps_left_nxt  = steps_left_r;
    line_active_nxt = line_active_r;
    last_nxt        = last_r;
    produce_nxt     = produce_r;
    color_nxt       = color_r;
    div_cnt_nxt     = div_cnt_r;
    px_nxt          = px_r;
    py_nxt          = py_r;
    if (cmd.load_start) begin
      pos_x_nxt       = {(COORD_BITS+1)'(in_start_x), {FRAC_BITS{1'b0}}};
      pos_y_nxt       = {(COORD_BITS+1)'(in_start_y), {FRAC_BITS{1'b0}}};
      longest_nxt     = longest_in;
      neg_x_nxt       = dx[COORD_BITS];
      neg_y_nxt       = dy[COORD_BITS];
      steps_left_nxt  = longest_in;
      line_active_nxt = (longest_in != '0);
      last_nxt        = (longest_in == '0);
      produce_nxt     = 1'b1;
      color_nxt       = in_line_color;
      div_cnt_nxt     = '0;
    end
    if (cmd.load_step) begin
      steps_left_nxt  = steps_left_r - COORD_BITS'(1);
      last_nxt        = (steps_left_r == COORD_BITS'(1));
      line_active_nxt = (steps_left_r != COORD_BITS'(1));
      produce_nxt     = 1'b1;
    end
    if (cmd.load_none) begin
      produce_nxt = 1'b0;
    end
    if (cmd.div_run) begin
      div_cnt_nxt = div_cnt_r + CNT_W'(1);
    end
    if (cmd.div_fin) begin
      // A zero-length line has no valid quotient: hold still.
      if (longest_r == '0) begin
        step_x_nxt = '0;
        step_y_nxt = '0;
      end else begin
        step_x_nxt = neg_x_r ? -qx_s : qx_s;
        step_y_nxt = neg_y_r ? -qy_s : qy_s;
      end
    end
    if (cmd.rnd) begin
      px_nxt    = rx_sum[POS_W-1:FRAC_BITS];
      py_nxt    = ry_sum[POS_W-1:FRAC_BITS];
      pos_x_nxt = pos_x_r + POS_W'(step_x_r);
      pos_y_nxt = pos_y_r + POS_W'(step_y_r);
    end
  end

  always_comb begin
    out_produced_nxt    = out_produced_r;
    out_visible_nxt     = out_visible_r;
    out_pixel_x_nxt     = out_pixel_x_r;
    out_pixel_y_nxt     = out_pixel_y_r;
    out_address_nxt     = out_address_r;
    out_pixel_color_nxt = out_pixel_color_r;
    out_last_nxt        = out_last_r;
    if (cmd.out_load) begin
      if (produce_r) begin
        out_produced_nxt    = 1'b1;
        out_visible_nxt     = vis;
        out_pixel_x_nxt     = px_r[COORD_BITS-1:0];
        out_pixel_y_nxt     = py_r[COORD_BITS-1:0];
        out_address_nxt     = vis ? ADDR_BITS'(prod + PROD_W'(px_r[COORD_BITS-1:0])) : '0;
        out_pixel_color_nxt = color_r;
        out_last_nxt        = last_r;
      end else begin
        out_produced_nxt    = 1'b0;
        out_visible_nxt     = 1'b0;
        out_pixel_x_nxt     = '0;
        out_pixel_y_nxt     = '0;
        out_address_nxt     = '0;
        out_pixel_color_nxt = '0;
        out_last_nxt        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_width_r   <= WIDTH_RST;
      win_height_r  <= HEIGHT_RST;
      steps_left_r  <= '0;
      line_active_r <= 1'b0;
      last_r        <= 1'b0;
      produce_r     <= 1'b0;
      div_cnt_r     <= '0;
    end else begin
      win_width_r   <= win_width_nxt;
      win_height_r  <= win_height_nxt;
      steps_left_r  <= steps_left_nxt;
      line_active_r <= line_active_nxt;
      last_r        <= last_nxt;
      produce_r     <= produce_nxt;
      div_cnt_r     <= div_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_x_r           <= pos_x_nxt;
    pos_y_r           <= pos_y_nxt;
    step_x_r          <= step_x_nxt;
    step_y_r          <= step_y_nxt;
    longest_r         <= longest_nxt;
    neg_x_r           <= neg_x_nxt;
    neg_y_r           <= neg_y_nxt;
    color_r           <= color_nxt;
    px_r              <= px_nxt;
    py_r              <= py_nxt;
    out_produced_r    <= out_produced_nxt;
    out_visible_r     <= out_visible_nxt;
    out_pixel_x_r     <= out_pixel_x_nxt;
    out_pixel_y_r     <= out_pixel_y_nxt;
    out_address_r     <= out_address_nxt;
    out_pixel_color_r <= out_pixel_color_nxt;
    out_last_r        <= out_last_nxt;
  end

  assign out_produced    = out_produced_r;
  assign out_visible     = out_visible_r;
  assign out_pixel_x     = out_pixel_x_r;
  assign out_pixel_y     = out_pixel_y_r;
  assign out_address     = out_address_r;
  assign out_pixel_color = out_pixel_color_r;
  assign out_last        = out_last_r;

endmodule

>>> sv/dlr_ctrl.sv
// Controller: sequences start, divide, round and result beats.
module dlr_ctrl import dlr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  dlr_status_t status,
  output dlr_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!status.act_step) begin
            state_nxt = ST_DIV;
          end else if (status.line_active) begin
            state_nxt = ST_RND;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: state_nxt = ST_RND;
      ST_RND: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!status.act_step) begin
            cmd.load_start = 1'b1;
          end else if (status.line_active) begin
            cmd.load_step = 1'b1;
          end else begin
            cmd.load_none = 1'b1;
          end
        end
      end
      ST_DIV:  cmd.div_run  = 1'b1;
      ST_FIN:  cmd.div_fin  = 1'b1;
      ST_RND:  cmd.rnd      = 1'b1;
      ST_OUT:  cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input beat accepted but block stayed idle");

  a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && status.div_done) |=> (state_r == ST_FIN))
    else $error("divider finished without rounding the increments");

  a_rnd_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RND) |=> (state_r == ST_OUT))
    else $error("rounded pixel not sent to the result stage");

  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.out_load))
    else $error("result valid raised without a result load");
`endif

endmodule

>>> tb/sv/tb_dda_line_rasterizer_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the DDA line rasterizer top level.
module tb_dda_line_rasterizer_top;
  import dlr_pkg::*;

  localparam int CB   = DEF_COORD_BITS;
  localparam int FB   = DEF_FRAC_BITS;
  localparam int CMAX = (1 << (CB - 1)) - 1;
  localparam int CMIN = -(1 << (CB - 1));

  // Settle for longer than a start beat occupies the block.
  localparam int SETTLE_CYCLES = FB + 12;
  // Slowest run: ~1400 beats, all of them start beats, plus random gaps on both sides,
  // several times over.
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int IDLE_PCT = 22;

  typedef struct packed {
    logic                  action;
    logic signed [CB-1:0]  sx;
    logic signed [CB-1:0]  sy;
    logic signed [CB-1:0]  ex;
    logic signed [CB-1:0]  ey;
    logic [COLOR_BITS-1:0] color;
  } beat_t;

  typedef struct packed {
    logic                  produced;
    logic                  visible;
    logic signed [CB-1:0]  x;
    logic signed [CB-1:0]  y;
    logic [ADDR_BITS-1:0]  address;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_action = ACT_START;
  logic signed [CB-1:0]  in_start_x = '0;
  logic signed [CB-1:0]  in_start_y = '0;
  logic signed [CB-1:0]  in_end_x = '0;
  logic signed [CB-1:0]  in_end_y = '0;
  logic [COLOR_BITS-1:0] in_line_color = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_produced;
  logic                  out_visible;
  logic signed [CB-1:0]  out_pixel_x;
  logic signed [CB-1:0]  out_pixel_y;
  logic [ADDR_BITS-1:0]  out_address;
  logic [COLOR_BITS-1:0] out_pixel_color;
  logic                  out_last;

  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_WIDTH;
  logic [WIN_BITS-1:0]     cfg_data = '0;

  // Shadow of the window registers and of the line walker.
  logic [WIN_BITS-1:0]   win_w = WIDTH_RST;
  logic [WIN_BITS-1:0]   win_h = HEIGHT_RST;
  longint                walk_pos_x = 0;
  longint                walk_pos_y = 0;
  longint                walk_inc_x = 0;
  longint                walk_inc_y = 0;
  longint                walk_left = 0;
  logic [COLOR_BITS-1:0] walk_color = '0;
  bit                    walk_active = 1'b0;

  pixel_t      pending_pixels[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  // High during the stretch with no gaps and no stalls on either side.
  bit          calm = 1'b0;

  dda_line_rasterizer_top dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Line walker prediction
  // ---------------------------------------------------------------------------

  // Per-step increment |delta| / span in fixed point, ties away from zero,
  // carrying the sign of delta.
  function automatic longint step_increment(longint delta, longint span);
    longint mag, num, quo;
    if (span <= 0) return 0;
    mag = (delta < 0) ? -delta : delta;
    num = mag <<< FB;
    quo = num / span;
    if ((num % span) * 2 >= span) quo = quo + 1;
    return (delta < 0) ? -quo : quo;
  endfunction

  // Round a fixed-point position to the nearest pixel, ties away from zero.
  function automatic longint round_coord(longint p);
    longint half;
    half = longint'(1) <<< (FB - 1);
    if (p < 0) return -((-p + half) >>> FB);
    return (p + half) >>> FB;
  endfunction

  // Form the pixel at the current position, then advance the position.
  function automatic pixel_t emit_pixel(bit is_last);
    pixel_t px;
    longint rx, ry;
    rx = round_coord(walk_pos_x);
    ry = round_coord(walk_pos_y);
    px.produced = 1'b1;
    px.visible  = rx >= 0 && ry >= 0 && rx < longint'(win_w) && ry < longint'(win_h);
    px.x        = rx[CB-1:0];
    px.y        = ry[CB-1:0];
    px.address  = px.visible ? ADDR_BITS'(longint'(win_w) * ry + rx) : '0;
    px.color    = walk_color;
    px.last     = is_last;
    walk_pos_x  = walk_pos_x + walk_inc_x;
    walk_pos_y  = walk_pos_y + walk_inc_y;
    return px;
  endfunction

  // Expected pixel for one accepted input beat.
  function automatic pixel_t rasterize_beat(beat_t b);
    longint x0, y0, dx, dy, ax, ay, span;
    if (b.action == ACT_START) begin
      x0 = b.sx;
      y0 = b.sy;
      dx = longint'(b.ex) - x0;
      dy = longint'(b.ey) - y0;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      span = (ax >= ay) ? ax : ay;
      walk_inc_x  = step_increment(dx, span);
      walk_inc_y  = step_increment(dy, span);
      walk_pos_x  = x0 <<< FB;
      walk_pos_y  = y0 <<< FB;
      walk_color  = b.color;
      walk_left   = span;
      walk_active = span != 0;
      return emit_pixel(span == 0);
    end
    // A step with no line in flight yields an all-zero beat.
    if (!walk_active) return '0;
    walk_left = walk_left - 1;
    if (walk_left == 0) walk_active = 1'b0;
    return emit_pixel(walk_left == 0);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic signed [CB-1:0] clamp_coord(int v);
    if (v < CMIN) return CB'(CMIN);
    if (v > CMAX) return CB'(CMAX);
    return CB'(v);
  endfunction

  function automatic beat_t start_beat(int x0, int y0, int x1, int y1,
                                       logic [COLOR_BITS-1:0] color);
    beat_t b;
    b.action = ACT_START;
    b.sx     = clamp_coord(x0);
    b.sy     = clamp_coord(y0);
    b.ex     = clamp_coord(x1);
    b.ey     = clamp_coord(y1);
    b.color  = color;
    return b;
  endfunction

  // Step beats carry random, ignored coordinates and color.
  function automatic beat_t step_beat();
    beat_t b;
    b.action = ACT_STEP;
    b.sx     = CB'($urandom);
    b.sy     = CB'($urandom);
    b.ex     = CB'($urandom);
    b.ey     = CB'($urandom);
    b.color  = $urandom;
    return b;
  endfunction

  // Half the origins land around the window so that clipping edges get hit.
  function automatic int pick_origin(int unsigned extent);
    if ($urandom_range(1) == 0) return int'($urandom_range(extent + 16)) - 8;
    return int'($urandom_range(8191)) - 4096;
  endfunction

  // Mostly short deltas, some medium, a few spanning the whole range.
  function automatic int pick_delta();
    int unsigned r, m;
    r = $urandom_range(99);
    if (r < 70) m = $urandom_range(24);
    else if (r < 95) m = $urandom_range(200);
    else m = $urandom_range(8191);
    return ($urandom_range(1) == 1) ? -int'(m) : int'(m);
  endfunction

  // Present one beat, hold it until accepted, record its expected pixel.
  // Valid stays high afterwards; a gap before the next beat or a drain lowers it.
  task automatic send_beat(beat_t b);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_action     <= b.action;
    in_start_x    <= b.sx;
    in_start_y    <= b.sy;
    in_end_x      <= b.ex;
    in_end_y      <= b.ey;
    in_line_color <= b.color;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_pixels.insert(pending_pixels.size(), rasterize_beat(b));
  endtask

  task automatic send_line(int x0, int y0, int x1, int y1,
                           logic [COLOR_BITS-1:0] color, int unsigned steps);
    send_beat(start_beat(x0, y0, x1, y1, color));
    repeat (steps) send_beat(step_beat());
  endtask

  // Drop valid, wait for every expected pixel, then let the block settle.
  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(logic [CFG_IDX_BITS-1:0] idx, logic [WIN_BITS-1:0] value);
    drain_pixels();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_WIDTH) win_w = value;
    else win_h = value;
  endtask

  // Random lines: mostly walked to the end, some abandoned by a new start,
  // some followed by stray steps after the last pixel.
  task automatic run_random_lines(int unsigned budget);
    int unsigned sent, span, steps, pick;
    int x0, y0, dx, dy, ax, ay;
    logic signed [CB-1:0] sx, sy, ex, ey;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_beat(step_beat());
        sent = sent + 1;
      end else begin
        if (pick < 10) begin
          sx = CB'($urandom);
          sy = CB'($urandom);
          ex = CB'($urandom);
          ey = CB'($urandom);
        end else begin
          x0 = pick_origin(win_w);
          y0 = pick_origin(win_h);
          sx = clamp_coord(x0);
          sy = clamp_coord(y0);
          ex = clamp_coord(x0 + pick_delta());
          ey = clamp_coord(y0 + pick_delta());
        end
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        span = (ax >= ay) ? ax : ay;
        // Keep huge lines short: walk a few pixels, then drop them.
        if (span > 300) steps = $urandom_range(12);
        else if (span > 0 && $urandom_range(99) < 15) steps = $urandom_range(span - 1);
        else steps = span;
        if (steps == span && $urandom_range(99) < 10) steps = steps + 1;
        // Stay within the beat budget of this call.
        if (steps > budget - sent - 1) steps = budget - sent - 1;
        send_line(sx, sy, ex, ey, $urandom, steps);
        sent = sent + 1 + steps;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Step out of reset with no line loaded: expect an all-zero beat.
  task automatic test_step_without_line();
    send_beat(step_beat());
  endtask

  task automatic test_directed_lines();
    // zero-length line, then a step after it finishes
    send_line(0, 0, 0, 0, '1, 1);
    // half-pixel ties round away from zero, both directions
    send_line(0, 0, 2, 1, 32'h1234_5678, 2);
    send_line(0, 0, -2, -1, 32'hA5A5_5A5A, 2);
    // diagonal across the bottom-right window corner
    send_line(WIDTH_RST - 2, HEIGHT_RST - 2, WIDTH_RST + 1, HEIGHT_RST + 1,
              32'h0F0F_0F0F, 3);
    // full-range diagonals, dropped by the next start
    send_line(CMIN, CMIN, CMAX, CMAX, '0, 2);
    send_line(CMAX, CMIN, CMIN, CMAX, '1, 1);
    // steep line, minor axis barely moving
    send_line(5, 0, 6, 3, 32'hDEAD_BEEF, 3);
    drain_pixels();
  endtask

  task automatic test_random_traffic();
    run_random_lines(500);
    drain_pixels();
  endtask

  // Long stretch with no gaps on the input and no stalls on the output.
  task automatic test_back_to_back();
    calm = 1'b1;
    run_random_lines(250);
    drain_pixels();
    calm = 1'b0;
  endtask

  // Walk through window sizes: the extremes, zero (nothing visible),
  // widths past 4096 (address wraps) and one random size.
  task automatic test_window_settings();
    int unsigned sizes_w[7];
    int unsigned sizes_h[7];
    sizes_w = '{1, 8191, 0, 800, 4096, 0, 1};
    sizes_h = '{1, 8191, 600, 0, 4096, 0, 1};
    sizes_w[6] = $urandom_range(1, 4096);
    sizes_h[6] = $urandom_range(1, 4096);
    for (int i = 0; i < 7; i++) begin
      write_window(CFG_WIDTH, WIN_BITS'(sizes_w[i]));
      write_window(CFG_HEIGHT, WIN_BITS'(sizes_h[i]));
      run_random_lines(80);
    end
    drain_pixels();
  endtask

  // ---------------------------------------------------------------------------
  // Result check: compare each accepted output beat with the oldest pixel.
  // ---------------------------------------------------------------------------

  function automatic void match_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("output beat with no pixel expected");
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        match_field("produced", want.produced, out_produced);
        match_field("visible", want.visible, out_visible);
        match_field("pixel_x", want.x, out_pixel_x);
        match_field("pixel_y", want.y, out_pixel_y);
        match_field("address", want.address, out_address);
        match_field("pixel_color", want.color, out_pixel_color);
        match_field("last", want.last, out_last);
      end
    end
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_step_without_line();
    test_directed_lines();
    test_random_traffic();
    test_back_to_back();
    test_window_settings();
    drain_pixels();
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
